// ===== hw/rtl/pisd_pkg.sv =====
// ----------------------------------------------------------------------------
// pisd_pkg
// Shared widths, register indexes, sequencer states and the CORDIC angle
// table for the phasor increment start detector.
// ----------------------------------------------------------------------------
package pisd_pkg;

    localparam int MAG_W    = 24;
    localparam int ANG_W    = 16;
    localparam int TIME_W   = 48;
    localparam int SAMP_W   = 16;
    localparam int ATH_W    = 15;
    localparam int RATE_W   = 32;
    localparam int CFG_IX_W = 3;
    localparam int CFG_W    = 32;

    localparam int GUARD    = 8;
    localparam int XY_W     = 34;
    localparam int Z_W      = 18;
    localparam int STEPS    = 14;
    localparam int STEP_W   = 4;

    localparam logic [15:0] INV_GAIN = 16'd39797;

    // configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_MAG_TH  = 3'd0;
    localparam logic [CFG_IX_W-1:0] CFG_ANG_TH  = 3'd1;
    localparam logic [CFG_IX_W-1:0] CFG_EPS_MAG = 3'd2;
    localparam logic [CFG_IX_W-1:0] CFG_EPS_ANG = 3'd3;
    localparam logic [CFG_IX_W-1:0] CFG_WARMUP  = 3'd4;
    localparam logic [CFG_IX_W-1:0] CFG_RATE    = 3'd5;

    localparam logic [RATE_W-1:0] RATE_RESET = 32'd214748;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_CORD = 4'b0100,
        ST_SQ   = 4'b1000
    } state_t;

    // arctangent of 2^-i in turns times 65536
    function automatic logic [13:0] atan_q16(input logic [STEP_W-1:0] i);
        logic [13:0] r;
        case (i)
            4'd0:    r = 14'd8192;
            4'd1:    r = 14'd4836;
            4'd2:    r = 14'd2555;
            4'd3:    r = 14'd1297;
            4'd4:    r = 14'd651;
            4'd5:    r = 14'd326;
            4'd6:    r = 14'd163;
            4'd7:    r = 14'd81;
            4'd8:    r = 14'd41;
            4'd9:    r = 14'd20;
            4'd10:   r = 14'd10;
            4'd11:   r = 14'd5;
            4'd12:   r = 14'd3;
            4'd13:   r = 14'd1;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

    // absolute value of a wrapped angle; half a turn stays positive
    function automatic logic [ANG_W:0] ang_abs(input logic [ANG_W-1:0] d);
        logic [ANG_W:0] r;
        if (d[ANG_W-1])
            r = (ANG_W+1)'(~{1'b1, d}) + (ANG_W+1)'(1);
        else
            r = {1'b0, d};
        return r;
    endfunction

endpackage

// ===== hw/rtl/pisd_in_if.sv =====
// ----------------------------------------------------------------------------
// pisd_in_if
// Input channel: one current phasor with sample number and timestamp.
// ----------------------------------------------------------------------------
interface pisd_in_if;
    logic                          valid;
    logic                          ready;
    logic [pisd_pkg::MAG_W-1:0]    cur_mag;
    logic signed [pisd_pkg::ANG_W-1:0] cur_angle;
    logic [pisd_pkg::SAMP_W-1:0]   sample_number;
    logic [pisd_pkg::TIME_W-1:0]   time_us;

    modport source (output valid, cur_mag, cur_angle, sample_number, time_us,
                    input ready);
    modport sink   (input valid, cur_mag, cur_angle, sample_number, time_us,
                    output ready);
endinterface

// ===== hw/rtl/pisd_out_if.sv =====
// ----------------------------------------------------------------------------
// pisd_out_if
// Result channel: start and block flags with the latched start time.
// ----------------------------------------------------------------------------
interface pisd_out_if;
    logic                         valid;
    logic                         ready;
    logic                         start_res;
    logic                         block;
    logic [pisd_pkg::TIME_W-1:0]  start_time;

    modport source (output valid, start_res, block, start_time, input ready);
    modport sink   (input valid, start_res, block, start_time, output ready);
endinterface

// ===== hw/rtl/phasor_increment_start_detector.sv =====
// ----------------------------------------------------------------------------
// phasor_increment_start_detector
// Sequence: a warm-up item is reported straight from idle; any other item
// runs 8 multiply steps, 14 CORDIC steps plus one handoff, then 5 square and
// compare steps. Items do not overlap: the shared multiplier and the CORDIC
// unit are used in turn, so a new item waits for the result to transfer.
// Reset: state, flags, start time, configuration and held and reference
// registers return to defaults; the working registers are not reset.
// ----------------------------------------------------------------------------
module phasor_increment_start_detector (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pisd_pkg::CFG_IX_W-1:0]     cfg_index,
    input  logic [pisd_pkg::CFG_W-1:0]        cfg_data,
    pisd_in_if.sink                           in_ch,
    pisd_out_if.source                        out_ch
);
    import pisd_pkg::*;

    // configuration
    logic [MAG_W-1:0]  mag_th_reg, eps_mag_reg;
    logic [ATH_W-1:0]  ang_th_reg, eps_ang_reg;
    logic [SAMP_W-1:0] warmup_reg;
    logic [RATE_W-1:0] rate_reg;

    // detector state
    state_t            state_reg, state_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              have_cur_reg, have_cur_next;
    logic              have_ref_reg, have_ref_next;
    logic              start_reg, start_next;
    logic              block_reg, block_next;
    logic              out_vld_reg, out_vld_next;
    logic [MAG_W-1:0]  held_mag_reg, held_mag_next, ref_mag_reg, ref_mag_next;
    logic [ANG_W-1:0]  held_ang_reg, held_ang_next, ref_ang_reg, ref_ang_next;
    logic [TIME_W-1:0] held_time_reg, held_time_next, ref_time_reg, ref_time_next;
    logic [TIME_W-1:0] stamp_reg, stamp_next;

    // working registers
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [ANG_W-1:0]  ang_reg, ang_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] acc_reg, acc_next;
    logic [ANG_W-1:0]  phc_reg, phc_next, phr_reg, phr_next;
    logic [ANG_W:0]    dabs_reg, dabs_next;
    logic signed [27:0] ex_reg, ex_next, ey_reg, ey_next;
    logic [56:0]       sum_reg, sum_next;
    logic [63:0]       s100_reg, s100_next;
    logic [47:0]       thr2_reg, thr2_next;

    // shared units
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;
    logic              cord_start, cord_done;
    logic signed [XY_W-1:0] cord_x, cord_y, cx_in;
    logic signed [Z_W-1:0]  cz_in;

    // combinational helpers
    logic              in_xfer, out_xfer, upd, warm, hit;
    logic [MAG_W-1:0]  dm;
    logic [ANG_W:0]    da;
    logic [ANG_W-1:0]  rc, rp, dphi;
    logic [TIME_W-1:0] t_sel, acc_sum;
    logic [1:0]        chunk;
    logic [27:0]       ax, ay;
    logic signed [35:0] dx, dy;

    pisd_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    pisd_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .x_in  (cx_in),
        .z_in  (cz_in),
        .done  (cord_done),
        .x_out (cord_x),
        .y_out (cord_y)
    );

    assign in_ch.ready = (state_reg == ST_IDLE) && !out_vld_reg;
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_xfer    = out_vld_reg && out_ch.ready;

    assign out_ch.valid      = out_vld_reg;
    assign out_ch.start_res  = start_reg;
    assign out_ch.block      = block_reg;
    assign out_ch.start_time = stamp_reg;

    // held-phasor change test on the incoming item
    always_comb
    begin
        dm   = (in_ch.cur_mag > held_mag_reg) ? in_ch.cur_mag - held_mag_reg
                                              : held_mag_reg - in_ch.cur_mag;
        da   = ang_abs(in_ch.cur_angle - held_ang_reg);
        upd  = !have_cur_reg || (dm > eps_mag_reg) || (da > (ANG_W+1)'(eps_ang_reg));
        warm = (in_ch.sample_number < warmup_reg) || !have_ref_reg;
    end

    // rotated angles and their wrapped difference
    always_comb
    begin
        rc   = (mag_reg == '0) ? '0 : ang_reg - phc_reg;
        rp   = (ref_mag_reg == '0) ? '0 : ref_ang_reg - phr_reg;
        dphi = rp - rc;
        cz_in = Z_W'(signed'(dphi));
        cx_in = XY_W'(mul_p[47:16]);
        if (cz_in > Z_W'(16384))
        begin
            cx_in = -cx_in;
            cz_in = cz_in - Z_W'(32768);
        end
        else if (cz_in < -Z_W'(16384))
        begin
            cx_in = -cx_in;
            cz_in = cz_in + Z_W'(32768);
        end
    end

    // shared multiplier operands
    always_comb
    begin
        chunk = (cnt_reg < 3'd3) ? 2'(cnt_reg) : 2'(cnt_reg - 3'd3);
        t_sel = (cnt_reg < 3'd3) ? held_time_reg : ref_time_reg;
        ax    = ex_reg[27] ? 28'(-ex_reg) : 28'(ex_reg);
        ay    = ey_reg[27] ? 28'(-ey_reg) : 28'(ey_reg);
        mul_a = rate_reg;
        case (chunk)
            2'd0:    mul_b = 32'(t_sel[15:0]);
            2'd1:    mul_b = 32'(t_sel[31:16]);
            default: mul_b = 32'(t_sel[47:32]);
        endcase
        if (state_reg == ST_MUL && cnt_reg == 3'd6)
        begin
            mul_a = {ref_mag_reg, 8'd0};
            mul_b = 32'(INV_GAIN);
        end
        else if (state_reg == ST_SQ)
        begin
            case (cnt_reg)
                3'd0:    begin mul_a = 32'(ax); mul_b = 32'(ax); end
                3'd1:    begin mul_a = 32'(ay); mul_b = 32'(ay); end
                default: begin mul_a = 32'(mag_th_reg); mul_b = 32'(mag_th_reg); end
            endcase
        end
    end

    // phase accumulation of the partial products
    always_comb
    begin
        case (cnt_reg)
            3'd1, 3'd4: acc_sum = mul_p[47:0];
            3'd2, 3'd5: acc_sum = acc_reg + {mul_p[31:0], 16'd0};
            default:    acc_sum = acc_reg + {mul_p[15:0], 32'd0};
        endcase
    end

    // rounded difference components from the rotated reference
    always_comb
    begin
        dx = signed'({4'd0, mag_reg, 8'd0}) - 36'(cord_x) + 36'sd128;
        dy = 36'sd128 - 36'(cord_y);
        hit = (64'(sum_reg) > 64'(thr2_reg)) ||
              ((s100_reg > 64'(thr2_reg)) && (dabs_reg > (ANG_W+1)'(ang_th_reg)));
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        have_cur_next  = have_cur_reg;
        have_ref_next  = have_ref_reg;
        start_next     = start_reg;
        block_next     = block_reg;
        out_vld_next   = out_vld_reg && !out_xfer;
        held_mag_next  = held_mag_reg;
        held_ang_next  = held_ang_reg;
        held_time_next = held_time_reg;
        ref_mag_next   = ref_mag_reg;
        ref_ang_next   = ref_ang_reg;
        ref_time_next  = ref_time_reg;
        stamp_next     = stamp_reg;
        mag_next       = mag_reg;
        ang_next       = ang_reg;
        now_next       = now_reg;
        acc_next       = acc_reg;
        phc_next       = phc_reg;
        phr_next       = phr_reg;
        dabs_next      = dabs_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        sum_next       = sum_reg;
        s100_next      = s100_reg;
        thr2_next      = thr2_reg;
        cord_start     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    mag_next      = in_ch.cur_mag;
                    ang_next      = in_ch.cur_angle;
                    now_next      = in_ch.time_us;
                    have_cur_next = 1'b1;
                    if (upd)
                    begin
                        held_mag_next  = in_ch.cur_mag;
                        held_ang_next  = in_ch.cur_angle;
                        held_time_next = in_ch.time_us;
                    end
                    if (warm)
                    begin
                        // reload the reference and report at once
                        ref_mag_next  = in_ch.cur_mag;
                        ref_ang_next  = in_ch.cur_angle;
                        ref_time_next = upd ? in_ch.time_us : held_time_reg;
                        have_ref_next = 1'b1;
                        start_next    = 1'b0;
                        block_next    = 1'b1;
                        out_vld_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                        cnt_next   = '0;
                    end
                end
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg != 3'd0)
                    acc_next = acc_sum;
                if (cnt_reg == 3'd3)
                    phc_next = acc_sum[47:32];
                if (cnt_reg == 3'd6)
                    phr_next = acc_sum[47:32];
                if (cnt_reg == 3'd7)
                begin
                    dabs_next  = ang_abs(dphi);
                    cord_start = 1'b1;
                    state_next = ST_CORD;
                end
            end
            ST_CORD:
            begin
                if (cord_done)
                begin
                    ex_next    = 28'(dx >>> GUARD);
                    ey_next    = 28'(dy >>> GUARD);
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cnt_next = cnt_reg + 3'd1;
                case (cnt_reg)
                    3'd1: sum_next = mul_p[56:0];
                    3'd2: sum_next = sum_reg + mul_p[56:0];
                    3'd3:
                    begin
                        thr2_next = mul_p[47:0];
                        s100_next = {sum_reg, 6'd0} + {1'b0, sum_reg, 5'd0}
                                  + {4'd0, sum_reg, 2'd0};
                    end
                    3'd4:
                    begin
                        // decide and refresh the reference when quiet
                        if (hit)
                        begin
                            if (!start_reg)
                            begin
                                start_next = 1'b1;
                                stamp_next = now_reg;
                            end
                            block_next = 1'b0;
                        end
                        else
                        begin
                            ref_mag_next  = mag_reg;
                            ref_ang_next  = ang_reg;
                            ref_time_next = held_time_reg;
                            start_next    = 1'b0;
                            block_next    = 1'b1;
                        end
                        out_vld_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    default: ;
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold configuration and detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_th_reg    <= '0;
            ang_th_reg    <= '0;
            eps_mag_reg   <= '0;
            eps_ang_reg   <= '0;
            warmup_reg    <= '0;
            rate_reg      <= RATE_RESET;
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            have_cur_reg  <= 1'b0;
            have_ref_reg  <= 1'b0;
            start_reg     <= 1'b0;
            block_reg     <= 1'b0;
            out_vld_reg   <= 1'b0;
            held_mag_reg  <= '0;
            held_ang_reg  <= '0;
            held_time_reg <= '0;
            ref_mag_reg   <= '0;
            ref_ang_reg   <= '0;
            ref_time_reg  <= '0;
            stamp_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAG_TH:  mag_th_reg  <= cfg_data[MAG_W-1:0];
                    CFG_ANG_TH:  ang_th_reg  <= cfg_data[ATH_W-1:0];
                    CFG_EPS_MAG: eps_mag_reg <= cfg_data[MAG_W-1:0];
                    CFG_EPS_ANG: eps_ang_reg <= cfg_data[ATH_W-1:0];
                    CFG_WARMUP:  warmup_reg  <= cfg_data[SAMP_W-1:0];
                    CFG_RATE:    rate_reg    <= cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            have_cur_reg  <= have_cur_next;
            have_ref_reg  <= have_ref_next;
            start_reg     <= start_next;
            block_reg     <= block_next;
            out_vld_reg   <= out_vld_next;
            held_mag_reg  <= held_mag_next;
            held_ang_reg  <= held_ang_next;
            held_time_reg <= held_time_next;
            ref_mag_reg   <= ref_mag_next;
            ref_ang_reg   <= ref_ang_next;
            ref_time_reg  <= ref_time_next;
            stamp_reg     <= stamp_next;
        end
    end

    // advance the working registers
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        ang_reg  <= ang_next;
        now_reg  <= now_next;
        acc_reg  <= acc_next;
        phc_reg  <= phc_next;
        phr_reg  <= phr_next;
        dabs_reg <= dabs_next;
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        sum_reg  <= sum_next;
        s100_reg <= s100_next;
        thr2_reg <= thr2_next;
    end

    a_vld_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (state_reg == ST_IDLE))
        else $error("result pending while busy");
    a_warm_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && warm) |=> (out_vld_reg && block_reg && !start_reg))
        else $error("warm-up item did not report block");
    a_start_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(start_reg) |-> (stamp_reg == $past(now_reg) && !block_reg))
        else $error("start rose without latching time");
    a_cord_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        cord_done |-> (state_reg == ST_CORD))
        else $error("cordic finished outside its phase");
endmodule

// ===== hw/rtl/pisd_mul.sv =====
// ----------------------------------------------------------------------------
// pisd_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module pisd_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);
    logic [63:0] p_reg;

    // register the product every cycle
    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;
endmodule

// ===== hw/rtl/pisd_cordic.sv =====
// ----------------------------------------------------------------------------
// pisd_cordic
// Iterative rotation CORDIC, one micro-rotation per cycle, fourteen steps.
// ----------------------------------------------------------------------------
module pisd_cordic (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [pisd_pkg::XY_W-1:0]     x_in,
    input  logic signed [pisd_pkg::Z_W-1:0]      z_in,
    output logic                                 done,
    output logic signed [pisd_pkg::XY_W-1:0]     x_out,
    output logic signed [pisd_pkg::XY_W-1:0]     y_out
);
    import pisd_pkg::*;

    logic                     run_reg, run_next;
    logic                     done_reg, done_next;
    logic [STEP_W-1:0]        i_reg, i_next;
    logic signed [XY_W-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic signed [XY_W-1:0]   xs, ys;
    logic signed [Z_W-1:0]    at;

    // one micro-rotation toward zero residual angle
    always_comb
    begin
        xs        = x_reg >>> i_reg;
        ys        = y_reg >>> i_reg;
        at        = signed'(Z_W'(atan_q16(i_reg)));
        run_next  = run_reg;
        done_next = 1'b0;
        i_next    = i_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            run_next = 1'b1;
            i_next   = '0;
            x_next   = x_in;
            y_next   = '0;
            z_next   = z_in;
        end
        else if (run_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            i_next = i_reg + STEP_W'(1);
            if (i_reg == STEP_W'(STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // hold control under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    // advance the datapath
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> run_reg)
        else $error("cordic did not start");
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && !start && i_reg == STEP_W'(STEPS - 1)) |=> (done_reg && !run_reg))
        else $error("cordic did not finish after last step");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("cordic done while running");
endmodule
